// ===== rtl/xhtd_pkg.sv =====
// Shared types and constants of the Xpress Huffman token decoder.
package xhtd_pkg;

  localparam int SymbolCount = 512;
  localparam int MaxCodeLen  = 15;
  localparam int ResultCap   = 17;
  localparam int SymW        = 9;
  localparam int CountW      = 10;
  localparam int StartW      = 16;

  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TRUNC   = 2'd1,
    ERR_OVERSUB = 2'd2,
    ERR_OVERRUN = 2'd3
  } err_e;

  typedef enum logic [4:0] {
    ST_TOP,
    ST_TABLE,
    ST_BUILD,
    ST_FILL_RD,
    ST_FILL_LO,
    ST_FILL_HI,
    ST_INIT,
    ST_DEC_SEARCH,
    ST_DEC_INDEX,
    ST_DEC_APPLY,
    ST_SYM_REFILL,
    ST_SYMBOL,
    ST_LEN8,
    ST_LEN16,
    ST_OFFSET,
    ST_OFF_REFILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  lit;
    logic [16:0] len;
    logic [15:0] off;
    err_e        err;
  } tok_t;

endpackage

// ===== rtl/xhtd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module xhtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/xpress_huffman_token_decoder.sv =====
// Xpress Huffman token decoder top level.
//
// channel  | dir | handshake           | payload
// s_axis   | in  | tvalid / tready     | tdata[7:0] in_byte
// m_axis   | out | tvalid / tready     | tdata literal/length/offset/error, tuser kind, tlast
// cfg      | in  | cfg_valid / ready   | cfg_data[31:0] input_length
//
// One byte is taken, then the sequencer runs until it needs another byte, has emitted
// ResultCap tokens or is done. After the 256th byte the code build walks the code lengths
// and fills the sorted-symbol table. A symbol needs the shared start-code compare search,
// index, sorted-symbol read and shift. Reset returns to awaiting a lengths table.
// A full output register with a held token stalls the sequencer.
module xpress_huffman_token_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] literal_value, [24:8] match_length,
                                      // [40:25] match_offset, [42:41] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  import xhtd_pkg::*;

  state_e              state_q, state_d;
  logic                running_q, running_d;
  logic                avail_q, avail_d;
  logic [7:0]          byte_q, byte_d;
  logic [4:0]          n_q, n_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         pos_q, pos_d;
  logic [15:0]         outpos_q, outpos_d;
  logic [31:0]         acc_q, acc_d;
  logic signed [5:0]   bits_q, bits_d;
  logic [7:0]          pend_q, pend_d;
  logic                half_q, half_d;
  logic                init2_q, init2_d;
  logic [7:0]          tidx_q, tidx_d;
  logic [7:0]          fbyte_q, fbyte_d;
  logic [3:0]          bl_q, bl_d;
  logic [16:0]         huf_q, huf_d;
  logic [CountW-1:0]   cum_q, cum_d;
  logic [CountW-1:0]   total_q, total_d;
  logic [CountW-1:0]   cnt_q [MaxCodeLen];
  logic [CountW-1:0]   cnt_d [MaxCodeLen];
  logic [CountW-1:0]   base_q [MaxCodeLen];
  logic [CountW-1:0]   base_d [MaxCodeLen];
  logic [CountW-1:0]   fill_q [MaxCodeLen];
  logic [CountW-1:0]   fill_d [MaxCodeLen];
  logic [StartW-1:0]   start_q [MaxCodeLen];
  logic [StartW-1:0]   start_d [MaxCodeLen];
  logic [3:0]          srch_l_q, srch_l_d;
  logic [3:0]          srch_b_q, srch_b_d;
  logic                hit_q, hit_d;
  logic [SymW-1:0]     sym_q, sym_d;
  logic [3:0]          ob_q, ob_d;
  logic [16:0]         mlen_q, mlen_d;
  logic [15:0]         moff_q, moff_d;
  tok_t                held_q, held_d;
  logic                held_valid_q, held_valid_d;
  tok_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                out_last_q, out_last_d;

  logic                cl_we;
  logic [7:0]          cl_wdata;
  logic [7:0]          cl_rdata;
  logic                so_we;
  logic [SymW-1:0]     so_waddr;
  logic [SymW-1:0]     so_wdata;
  logic [SymW-1:0]     so_raddr;
  logic [SymW-1:0]     so_rdata;

  logic                need_byte, byte_wait;
  logic [7:0]          fval;
  logic [31:0]         pos_inc;
  logic [15:0]         word;
  logic                can_emit, end_ok;
  logic [14:0]         hm;
  logic [3:0]          cand, lsel, sh, ob_sh;
  logic [15:0]         diff, sidx_full;
  logic signed [5:0]   bits_after_l, bits_after_ob, neg_bits;
  logic [15:0]         off_calc;
  logic [31:0]         refill_acc;
  logic [16:0]         huf_sum;
  logic [3:0]          bidx;

  xhtd_ram #(.WIDTH(8), .DEPTH(256)) u_cl_ram (
    .clk_i   (clk_i),
    .we_i    (cl_we),
    .waddr_i (tidx_q),
    .wdata_i (cl_wdata),
    .raddr_i (fbyte_q),
    .rdata_o (cl_rdata)
  );

  xhtd_ram #(.WIDTH(SymW), .DEPTH(SymbolCount)) u_so_ram (
    .clk_i   (clk_i),
    .we_i    (so_we),
    .waddr_i (so_waddr),
    .wdata_i (so_wdata),
    .raddr_i (so_raddr),
    .rdata_o (so_rdata)
  );

  assign s_axis_tready = !running_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.err, out_q.off, out_q.len, out_q.lit};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

  assign need_byte = pos_q < len_q;
  assign byte_wait = need_byte && !avail_q;
  assign fval      = need_byte ? byte_q : 8'd0;
  assign pos_inc   = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
  assign word      = {fval, pend_q};
  assign can_emit  = !(held_valid_q && out_valid_q && !m_axis_tready);
  assign end_ok    = can_emit;

  // start-code search and sorted-symbol index
  assign hm        = acc_q[31:17];
  assign cand      = srch_l_q | srch_b_q;
  assign lsel      = (srch_l_q == 4'd0) ? 4'd1 : srch_l_q;
  assign sh        = 4'(MaxCodeLen) - lsel;
  assign diff      = (16'({1'b0, hm}) >> sh) - (start_q[lsel - 4'd1] >> sh);
  assign sidx_full = 16'(base_q[lsel - 4'd1]) + diff;
  assign so_raddr  = sidx_full[SymW-1:0];

  assign bits_after_l  = bits_q - $signed({2'b00, lsel});
  assign bits_after_ob = bits_q - $signed({2'b00, ob_q});
  assign neg_bits      = 6'sd0 - bits_q;
  assign refill_acc    = acc_q | (32'(word) << neg_bits[4:0]);
  assign ob_sh         = ob_q;
  assign off_calc      = 16'(acc_q >> (6'd32 - {2'b00, ob_sh})) + (16'd1 << ob_sh);

  assign bidx    = bl_q - 4'd1;
  assign huf_sum = huf_q + 17'(cnt_q[bidx]);

  always_comb begin
    logic do_end;
    logic emit;
    tok_t tok;
    logic [3:0] nib;

    state_d      = state_q;
    running_d    = running_q;
    avail_d      = avail_q;
    byte_d       = byte_q;
    n_d          = n_q;
    len_d        = len_q;
    pos_d        = pos_q;
    outpos_d     = outpos_q;
    acc_d        = acc_q;
    bits_d       = bits_q;
    pend_d       = pend_q;
    half_d       = half_q;
    init2_d      = init2_q;
    tidx_d       = tidx_q;
    fbyte_d      = fbyte_q;
    bl_d         = bl_q;
    huf_d        = huf_q;
    cum_d        = cum_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    fill_d       = fill_q;
    start_d      = start_q;
    srch_l_d     = srch_l_q;
    srch_b_d     = srch_b_q;
    hit_d        = hit_q;
    sym_d        = sym_q;
    ob_d         = ob_q;
    mlen_d       = mlen_q;
    moff_d       = moff_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    cl_we        = 1'b0;
    cl_wdata     = fval;
    so_we        = 1'b0;
    so_waddr     = '0;
    so_wdata     = '0;
    do_end       = 1'b0;
    emit         = 1'b0;
    tok          = '0;
    nib          = '0;

    if (cfg_valid_i) begin
      len_d = cfg_data_i;
    end

    if (!running_q) begin
      if (s_axis_tvalid) begin
        byte_d    = s_axis_tdata;
        avail_d   = 1'b1;
        running_d = 1'b1;
        n_d       = '0;
      end
    end else if (n_q == 5'(ResultCap)) begin
      do_end = 1'b1;
    end else begin
      case (state_q)
        ST_TOP: begin
          if (pos_q >= len_q) begin
            if (can_emit) begin
              emit = 1'b1; tok.kind = KIND_ERROR; tok.err = ERR_OVERRUN;
              state_d = ST_DONE;
            end
          end else if (outpos_q == 16'd0) begin
            if ({1'b0, pos_q} + 33'(SymbolCount / 2) > {1'b0, len_q}) begin
              if (can_emit) begin
                emit = 1'b1; tok.kind = KIND_ERROR; tok.err = ERR_TRUNC;
                state_d = ST_DONE;
              end
            end else begin
              tidx_d = '0;
              for (int i = 0; i < MaxCodeLen; i++) cnt_d[i] = '0;
              state_d = ST_TABLE;
            end
          end else begin
            srch_l_d = '0;
            srch_b_d = 4'd8;
            state_d  = ST_DEC_SEARCH;
          end
        end
        ST_TABLE: begin
          if (byte_wait) begin
            do_end = 1'b1;
          end else begin
            avail_d = avail_q && !need_byte;
            pos_d   = pos_inc;
            cl_we   = 1'b1;
            for (int i = 0; i < MaxCodeLen; i++) begin
              cnt_d[i] = cnt_q[i] + CountW'(fval[3:0] == 4'(i + 1))
                                  + CountW'(fval[7:4] == 4'(i + 1));
            end
            tidx_d = tidx_q + 8'd1;
            if (tidx_q == 8'hFF) begin
              bl_d  = 4'd1;
              huf_d = '0;
              cum_d = '0;
              state_d = ST_BUILD;
            end
          end
        end
        ST_BUILD: begin
          if (huf_sum > (17'd1 << bl_q)) begin
            if (can_emit) begin
              emit = 1'b1; tok.kind = KIND_ERROR; tok.err = ERR_OVERSUB;
              state_d = ST_DONE;
            end
          end else begin
            start_d[bidx] = StartW'(huf_q << (4'(MaxCodeLen) - bl_q));
            base_d[bidx]  = cum_q;
            fill_d[bidx]  = cum_q;
            huf_d = huf_sum << 1;
            cum_d = cum_q + cnt_q[bidx];
            bl_d  = bl_q + 4'd1;
            if (bl_q == 4'(MaxCodeLen)) begin
              total_d = cum_q + cnt_q[bidx];
              fbyte_d = '0;
              state_d = ST_FILL_RD;
            end
          end
        end
        ST_FILL_RD: state_d = ST_FILL_LO;
        ST_FILL_LO, ST_FILL_HI: begin
          nib = (state_q == ST_FILL_LO) ? cl_rdata[3:0] : cl_rdata[7:4];
          if (nib != 4'd0) begin
            so_we    = 1'b1;
            so_waddr = fill_q[nib - 4'd1][SymW-1:0];
            so_wdata = {fbyte_q, state_q == ST_FILL_HI};
            fill_d[nib - 4'd1] = fill_q[nib - 4'd1] + CountW'(1);
          end
          if (state_q == ST_FILL_LO) begin
            state_d = ST_FILL_HI;
          end else begin
            fbyte_d = fbyte_q + 8'd1;
            if (fbyte_q == 8'hFF) begin
              half_d  = 1'b0;
              init2_d = 1'b0;
              state_d = ST_INIT;
            end else begin
              state_d = ST_FILL_RD;
            end
          end
        end
        ST_INIT, ST_SYM_REFILL, ST_LEN16, ST_OFF_REFILL: begin
          if (byte_wait) begin
            do_end = 1'b1;
          end else if (!half_q) begin
            avail_d = avail_q && !need_byte;
            pos_d   = pos_inc;
            pend_d  = fval;
            half_d  = 1'b1;
          end else if (state_q != ST_OFF_REFILL || can_emit) begin
            avail_d = avail_q && !need_byte;
            pos_d   = pos_inc;
            half_d  = 1'b0;
            case (state_q)
              ST_INIT: begin
                if (!init2_q) begin
                  acc_d   = {word, 16'd0};
                  init2_d = 1'b1;
                end else begin
                  acc_d   = {acc_q[31:16], word};
                  bits_d  = 6'sd16;
                  srch_l_d = '0;
                  srch_b_d = 4'd8;
                  state_d = ST_DEC_SEARCH;
                end
              end
              ST_SYM_REFILL: begin
                acc_d   = refill_acc;
                bits_d  = bits_q + 6'sd16;
                state_d = ST_SYMBOL;
              end
              ST_LEN16: begin
                mlen_d  = 17'(word) + 17'd3;
                state_d = ST_OFFSET;
              end
              default: begin
                acc_d    = refill_acc;
                bits_d   = bits_q + 6'sd16;
                emit     = 1'b1;
                tok.kind = KIND_MATCH;
                tok.len  = mlen_q;
                tok.off  = moff_q;
                outpos_d = outpos_q + mlen_q[15:0];
                state_d  = ST_TOP;
              end
            endcase
          end
        end
        ST_DEC_SEARCH: begin
          if ({1'b0, hm} >= start_q[cand - 4'd1]) begin
            srch_l_d = cand;
          end
          srch_b_d = srch_b_q >> 1;
          if (srch_b_q == 4'd1) state_d = ST_DEC_INDEX;
        end
        ST_DEC_INDEX: begin
          hit_d   = {1'b0, so_raddr} < total_q;
          state_d = ST_DEC_APPLY;
        end
        ST_DEC_APPLY: begin
          sym_d   = hit_q ? so_rdata : '0;
          acc_d   = acc_q << lsel;
          bits_d  = bits_after_l;
          state_d = bits_after_l[5] ? ST_SYM_REFILL : ST_SYMBOL;
        end
        ST_SYMBOL: begin
          if (!sym_q[8]) begin
            if (can_emit) begin
              emit = 1'b1; tok.kind = KIND_LIT; tok.lit = sym_q[7:0];
              outpos_d = outpos_q + 16'd1;
              state_d  = ST_TOP;
            end
          end else if (sym_q[7:0] == 8'd0 && {1'b0, pos_q} + 33'd1 >= {1'b0, len_q}) begin
            if (can_emit) begin
              emit = 1'b1; tok.kind = KIND_END;
              state_d = ST_DONE;
            end
          end else begin
            ob_d = sym_q[7:4];
            if (sym_q[3:0] == 4'hF) begin
              state_d = ST_LEN8;
            end else begin
              mlen_d  = 17'(sym_q[3:0]) + 17'd3;
              state_d = ST_OFFSET;
            end
          end
        end
        ST_LEN8: begin
          if (byte_wait) begin
            do_end = 1'b1;
          end else begin
            avail_d = avail_q && !need_byte;
            pos_d   = pos_inc;
            if (fval == 8'hFF) begin
              half_d  = 1'b0;
              state_d = ST_LEN16;
            end else begin
              mlen_d  = 17'(fval) + 17'd18;
              state_d = ST_OFFSET;
            end
          end
        end
        ST_OFFSET: begin
          if (bits_after_ob[5]) begin
            moff_d  = (ob_q != 4'd0) ? off_calc : 16'd1;
            acc_d   = acc_q << ob_q;
            bits_d  = bits_after_ob;
            half_d  = 1'b0;
            state_d = ST_OFF_REFILL;
          end else if (can_emit) begin
            acc_d    = acc_q << ob_q;
            bits_d   = bits_after_ob;
            emit     = 1'b1;
            tok.kind = KIND_MATCH;
            tok.len  = mlen_q;
            tok.off  = (ob_q != 4'd0) ? off_calc : 16'd1;
            outpos_d = outpos_q + mlen_q[15:0];
            state_d  = ST_TOP;
          end
        end
        ST_DONE: do_end = 1'b1;
        default: state_d = ST_DONE;
      endcase
    end

    if (emit) begin
      if (held_valid_q) begin
        out_d       = held_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      held_d       = tok;
      held_valid_d = 1'b1;
      n_d          = n_q + 5'd1;
    end

    if (do_end && end_ok) begin
      running_d = 1'b0;
      if (held_valid_q) begin
        out_d        = held_q;
        out_last_d   = 1'b1;
        out_valid_d  = 1'b1;
        held_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_TOP;
      running_q    <= 1'b0;
      avail_q      <= 1'b0;
      byte_q       <= '0;
      n_q          <= '0;
      len_q        <= '0;
      pos_q        <= '0;
      outpos_q     <= '0;
      acc_q        <= '0;
      bits_q       <= '0;
      pend_q       <= '0;
      half_q       <= 1'b0;
      init2_q      <= 1'b0;
      tidx_q       <= '0;
      fbyte_q      <= '0;
      bl_q         <= '0;
      huf_q        <= '0;
      cum_q        <= '0;
      total_q      <= '0;
      for (int i = 0; i < MaxCodeLen; i++) begin
        cnt_q[i]   <= '0;
        base_q[i]  <= '0;
        fill_q[i]  <= '0;
        start_q[i] <= '0;
      end
      srch_l_q     <= '0;
      srch_b_q     <= '0;
      hit_q        <= 1'b0;
      sym_q        <= '0;
      ob_q         <= '0;
      mlen_q       <= '0;
      moff_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      avail_q      <= avail_d;
      byte_q       <= byte_d;
      n_q          <= n_d;
      len_q        <= len_d;
      pos_q        <= pos_d;
      outpos_q     <= outpos_d;
      acc_q        <= acc_d;
      bits_q       <= bits_d;
      pend_q       <= pend_d;
      half_q       <= half_d;
      init2_q      <= init2_d;
      tidx_q       <= tidx_d;
      fbyte_q      <= fbyte_d;
      bl_q         <= bl_d;
      huf_q        <= huf_d;
      cum_q        <= cum_d;
      total_q      <= total_d;
      cnt_q        <= cnt_d;
      base_q       <= base_d;
      fill_q       <= fill_d;
      start_q      <= start_d;
      srch_l_q     <= srch_l_d;
      srch_b_q     <= srch_b_d;
      hit_q        <= hit_d;
      sym_q        <= sym_d;
      ob_q         <= ob_d;
      mlen_q       <= mlen_d;
      moff_q       <= moff_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Xpress Huffman token decoder: stream stimulus and token checks.
`timescale 1ns / 100ps

module tb_top;
  import xhtd_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int          SettleCycles = 1000;

  typedef enum int {
    PH_TOP, PH_TABLE, PH_INIT, PH_DECODE, PH_SYM_REFILL, PH_SYMBOL,
    PH_LEN8, PH_LEN16, PH_OFFSET, PH_OFF_REFILL, PH_DONE
  } dec_phase_e;

  typedef struct {
    tok_t tok;
    bit   last;
  } token_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  xpress_huffman_token_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // decoder state mirror
  logic [3:0]  lens_tab [SymbolCount];
  logic [8:0]  sym_order [SymbolCount];
  int unsigned len_count [16];
  int unsigned start_code [16];
  int unsigned len_base [16];
  int unsigned fb_len [256];
  int unsigned acc;
  int          bits_av;
  int unsigned in_pos;
  int unsigned out_pos;
  dec_phase_e  phase;
  int unsigned pend_lo;
  bit          half_rd;
  bit          init_2nd;
  int unsigned tab_idx;
  int unsigned held_sym;
  int unsigned off_bits;
  int unsigned m_len;
  int unsigned m_off;
  int unsigned in_len;
  bit          byte_av;

  token_exp_t  step_q[$];
  token_exp_t  token_q[$];
  int          fail_cnt = 0;
  int unsigned cycles = 0;
  bit          tx_gaps_en = 1'b1;
  bit          rx_stall_en = 1'b1;
  int          rx_hold = 0;

  function automatic bit build_code();
    int unsigned huf, cum, fb;
    int unsigned fill [16];
    int l;
    huf = 0;
    cum = 0;
    foreach (len_count[i]) len_count[i] = 0;
    foreach (sym_order[i]) sym_order[i] = '0;
    for (int s = 0; s < SymbolCount; s++) begin
      l = lens_tab[s];
      if (l > MaxCodeLen) return 1'b0;
      if (l != 0) len_count[l]++;
    end
    for (l = 1; l <= MaxCodeLen; l++) begin
      start_code[l] = huf << (MaxCodeLen - l);
      len_base[l] = cum;
      fill[l] = cum;
      huf += len_count[l];
      if (huf > (32'd1 << l)) return 1'b0;
      huf <<= 1;
      cum += len_count[l];
    end
    for (int s = 0; s < SymbolCount; s++) begin
      l = lens_tab[s];
      if (l != 0) begin
        sym_order[fill[l] & 511] = s[8:0];
        fill[l]++;
      end
    end
    for (l = 1; l <= MaxCodeLen; l++)
      for (fb = start_code[l] >> (MaxCodeLen - 8); fb < 256; fb++) fb_len[fb] = l;
    return 1'b1;
  endfunction

  function automatic void decode_symbol();
    int unsigned hm, l, sh, idx;
    hm = acc >> (32 - MaxCodeLen);
    l = fb_len[(hm >> (MaxCodeLen - 8)) & 8'hff];
    if (l < 1 || l > MaxCodeLen) l = 1;
    while (l > 1 && hm < start_code[l]) l--;
    sh = MaxCodeLen - l;
    idx = (hm >> sh) - (start_code[l] >> sh);
    held_sym = sym_order[(len_base[l] + idx) & 511];
    acc = acc << l;
    bits_av -= int'(l);
  endfunction

  function automatic bit get_byte(input logic [7:0] b, output int unsigned v);
    if (in_pos < in_len) begin
      if (!byte_av) return 1'b0;
      byte_av = 1'b0;
      v = b;
    end else begin
      v = 0;
    end
    if (in_pos != 32'hffff_ffff) in_pos++;
    return 1'b1;
  endfunction

  function automatic bit get_word(input logic [7:0] b, output int unsigned v);
    int unsigned t;
    if (!half_rd) begin
      if (!get_byte(b, t)) return 1'b0;
      pend_lo = t;
      half_rd = 1'b1;
    end
    if (!get_byte(b, t)) return 1'b0;
    half_rd = 1'b0;
    v = pend_lo | (t << 8);
    return 1'b1;
  endfunction

  function automatic void push_token(kind_e k, int unsigned lit, int unsigned len,
                                     int unsigned off, err_e e);
    token_exp_t t;
    t.tok.kind = k;
    t.tok.lit  = lit[7:0];
    t.tok.len  = len[16:0];
    t.tok.off  = off[15:0];
    t.tok.err  = e;
    t.last     = 1'b0;
    step_q.push_back(t);
  endfunction

  function automatic void finish_match();
    push_token(KIND_MATCH, 0, m_len, m_off, ERR_NONE);
    out_pos = (out_pos + m_len) & 32'hffff;
    phase = PH_TOP;
  endfunction

  function automatic bit advance(input logic [7:0] b);
    int unsigned v;
    case (phase)
      PH_TOP: begin
        if (in_pos >= in_len) begin
          push_token(KIND_ERROR, 0, 0, 0, ERR_OVERRUN);
          phase = PH_DONE;
        end else if (out_pos == 0) begin
          if (longint'(in_pos) + SymbolCount / 2 > longint'(in_len)) begin
            push_token(KIND_ERROR, 0, 0, 0, ERR_TRUNC);
            phase = PH_DONE;
          end else begin
            tab_idx = 0;
            phase = PH_TABLE;
          end
        end else begin
          phase = PH_DECODE;
        end
      end
      PH_TABLE: begin
        if (!get_byte(b, v)) return 1'b0;
        lens_tab[(2 * tab_idx) & 511]     = v[3:0];
        lens_tab[(2 * tab_idx + 1) & 511] = v[7:4];
        tab_idx++;
        if (tab_idx >= SymbolCount / 2) begin
          if (!build_code()) begin
            push_token(KIND_ERROR, 0, 0, 0, ERR_OVERSUB);
            phase = PH_DONE;
          end else begin
            half_rd = 1'b0;
            init_2nd = 1'b0;
            phase = PH_INIT;
          end
        end
      end
      PH_INIT: begin
        if (!get_word(b, v)) return 1'b0;
        if (!init_2nd) begin
          acc = v << 16;
          init_2nd = 1'b1;
        end else begin
          acc |= v;
          bits_av = 16;
          phase = PH_DECODE;
        end
      end
      PH_DECODE: begin
        decode_symbol();
        phase = (bits_av < 0) ? PH_SYM_REFILL : PH_SYMBOL;
      end
      PH_SYM_REFILL: begin
        if (!get_word(b, v)) return 1'b0;
        acc |= v << (-bits_av);
        bits_av += 16;
        phase = PH_SYMBOL;
      end
      PH_SYMBOL: begin
        if (held_sym < 256) begin
          push_token(KIND_LIT, held_sym, 0, 0, ERR_NONE);
          out_pos = (out_pos + 1) & 32'hffff;
          phase = PH_TOP;
        end else if (held_sym == 256 && longint'(in_pos) + 1 >= longint'(in_len)) begin
          push_token(KIND_END, 0, 0, 0, ERR_NONE);
          phase = PH_DONE;
        end else begin
          v = (held_sym - 256) & 8'hff;
          off_bits = v >> 4;
          if ((v & 4'hf) == 4'hf) begin
            phase = PH_LEN8;
          end else begin
            m_len = (v & 4'hf) + 3;
            phase = PH_OFFSET;
          end
        end
      end
      PH_LEN8: begin
        if (!get_byte(b, v)) return 1'b0;
        if (v == 8'hff) begin
          half_rd = 1'b0;
          phase = PH_LEN16;
        end else begin
          m_len = v + 15 + 3;
          phase = PH_OFFSET;
        end
      end
      PH_LEN16: begin
        if (!get_word(b, v)) return 1'b0;
        m_len = v + 3;
        phase = PH_OFFSET;
      end
      PH_OFFSET: begin
        if (off_bits != 0) begin
          m_off = (acc >> (32 - off_bits)) + (32'd1 << off_bits);
          acc = acc << off_bits;
        end else begin
          m_off = 1;
        end
        bits_av -= int'(off_bits);
        if (bits_av < 0) begin
          half_rd = 1'b0;
          phase = PH_OFF_REFILL;
        end else begin
          finish_match();
        end
      end
      PH_OFF_REFILL: begin
        if (!get_word(b, v)) return 1'b0;
        acc |= v << (-bits_av);
        bits_av += 16;
        finish_match();
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void predict_tokens(input logic [7:0] b);
    byte_av = 1'b1;
    step_q.delete();
    while (step_q.size() < ResultCap) begin
      if (!advance(b)) break;
    end
    foreach (step_q[i]) begin
      if (i == step_q.size() - 1) step_q[i].last = 1'b1;
      token_q.push_back(step_q[i]);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tokens(b);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] value);
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    in_len = value;
  endtask

  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'hff;
    if (r < 12) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_byte(stream_byte());
  endtask

  // tail bytes once the stream has finished must be swallowed silently
  task automatic send_tail();
    repeat (3) send_byte(8'($urandom));
  endtask

  task automatic test_empty_stream();
    write_length(32'd0);
    send_byte(8'($urandom));
    send_tail();
  endtask

  task automatic test_truncated_table();
    write_length($urandom_range(1, 255));
    send_byte(8'($urandom));
    send_tail();
  endtask

  task automatic test_oversubscribed_code();
    write_length(32'hffff_ffff);
    send_byte(8'h11);
    send_byte(8'($urandom_range(1, 15)) | 8'($urandom) & 8'hf0);
    repeat (254) send_byte(8'($urandom));
    send_tail();
  endtask

  // literals on 10 bits, end symbol on 2 bits, matches on 9 bits, one code left unused
  task automatic load_code_table();
    for (int i = 0; i < 256; i++) begin
      if (i < 128) send_byte(8'haa);
      else if (i == 128) send_byte(8'h92);
      else send_byte(8'h99);
    end
  endtask

  task automatic test_token_stream();
    write_length(32'hffff_ffff);
    load_code_table();
    send_random(100);
    stop_sending();
    wait_drained();
    rx_stall_en = 1'b0;
    tx_gaps_en  = 1'b0;
    send_random(40);
    rx_stall_en = 1'b1;
    tx_gaps_en  = 1'b1;
    write_length(in_pos + $urandom_range(5000, 32'h4000_0000));
    send_random(90);
  endtask

  task automatic test_stream_end();
    int guard;
    write_length(in_pos + $urandom_range(0, 6));
    guard = 0;
    while (phase != PH_DONE && guard < 300) begin
      send_byte(stream_byte());
      guard++;
    end
    send_tail();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_stall_en && $urandom_range(0, 5) == 0) rx_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    token_exp_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_q.size() == 0) begin
        $error("token with none expected: kind %0d", m_axis_tuser);
        fail_cnt++;
      end else begin
        e = token_q.pop_front();
        if (m_axis_tuser !== e.tok.kind) begin
          $error("token_kind exp %0d got %0d", e.tok.kind, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[7:0] !== e.tok.lit) begin
          $error("literal_value exp %0d got %0d", e.tok.lit, m_axis_tdata[7:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[24:8] !== e.tok.len) begin
          $error("match_length exp %0d got %0d", e.tok.len, m_axis_tdata[24:8]);
          fail_cnt++;
        end
        if (m_axis_tdata[40:25] !== e.tok.off) begin
          $error("match_offset exp %0d got %0d", e.tok.off, m_axis_tdata[40:25]);
          fail_cnt++;
        end
        if (m_axis_tdata[42:41] !== e.tok.err) begin
          $error("error_code exp %0d got %0d", e.tok.err, m_axis_tdata[42:41]);
          fail_cnt++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_token exp %0d got %0d", e.last, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int sel;
    foreach (lens_tab[i]) lens_tab[i] = '0;
    foreach (sym_order[i]) sym_order[i] = '0;
    foreach (len_count[i]) len_count[i] = 0;
    foreach (start_code[i]) start_code[i] = 0;
    foreach (len_base[i]) len_base[i] = 0;
    foreach (fb_len[i]) fb_len[i] = 0;
    acc = 0; bits_av = 0; in_pos = 0; out_pos = 0; phase = PH_TOP;
    pend_lo = 0; half_rd = 0; init_2nd = 0; tab_idx = 0; held_sym = 0;
    off_bits = 0; m_len = 0; m_off = 0; in_len = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one stream per run: the terminal condition is drawn per seed
    sel = $urandom_range(0, 9);
    case (sel)
      0: test_empty_stream();
      1: test_truncated_table();
      2: test_oversubscribed_code();
      default: begin
        test_token_stream();
        test_stream_end();
      end
    endcase

    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_cnt == 0 && token_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xhtd_pkg.sv
rtl/xhtd_ram.sv
rtl/xpress_huffman_token_decoder.sv
tb/tb_top.sv
